// File: src/dhcp_option_parser_top_macros.svh
// ----------------------------------------------------------------------------
// DHCP option parser assertion macros
// Shared concurrent assertion forms for the option parser checks.
// ----------------------------------------------------------------------------
`ifndef DHCP_OPTION_PARSER_TOP_MACROS_SVH
`define DHCP_OPTION_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DOP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DOP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dhcp_opt_pkg.sv
// ----------------------------------------------------------------------------
// DHCP option parser package
// Word types, option codes and parser state encodings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhcp_opt_pkg;

  localparam logic [7:0] CODE_PAD        = 8'd0;
  localparam logic [7:0] CODE_END        = 8'd255;
  localparam logic [7:0] CODE_NETMASK    = 8'd1;
  localparam logic [7:0] CODE_ROUTER     = 8'd3;
  localparam logic [7:0] CODE_DNS        = 8'd6;
  localparam logic [7:0] CODE_MSG_TYPE   = 8'd53;
  localparam logic [7:0] CODE_SERVER_ID  = 8'd54;
  localparam logic [7:0] CODE_CLASSLESS  = 8'd121;
  localparam logic [7:0] LEN_MSG_TYPE    = 8'd1;
  localparam logic [7:0] LEN_ADDR        = 8'd4;
  localparam logic [2:0] ADDR_BYTES      = 3'd4;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_LENGTH,
    PH_VALUE,
    PH_STOPPED
  } parse_phase_t;

  typedef enum logic [1:0] {
    RT_PREFIX,
    RT_DEST,
    RT_ROUTER
  } route_phase_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  message_type;
    logic        message_type_valid;
    logic [31:0] subnet_mask;
    logic [31:0] router_address;
    logic [31:0] dns_address;
    logic [31:0] server_address;
  } out_word_t;

endpackage

// File: src/dhcp_option_parser_top.sv
// ----------------------------------------------------------------------------
// DHCP option parser top level
// The result word is registered in the output register, or in the skid if it stalls.
// Throughput: one option byte per cycle; the input stalls while the skid holds a word.
// Reset clears the parse state, all kept fields and both result valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dhcp_option_parser_top_macros.svh"

module dhcp_option_parser_top (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  dhcp_opt_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output dhcp_opt_pkg::out_word_t out_word
);

  logic                    in_acc;
  logic                    res_push;
  logic                    out_take;
  dhcp_opt_pkg::out_word_t result;

  logic                    out_valid_r, out_valid_nxt;
  dhcp_opt_pkg::out_word_t out_data_r, out_data_nxt;
  logic                    skid_valid_r, skid_valid_nxt;
  dhcp_opt_pkg::out_word_t skid_data_r, skid_data_nxt;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign res_push  = in_acc && in_word.last_byte;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_data_r;

  dhcp_opt_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .word   (in_word),
    .result (result)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (res_push) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (res_push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `DOP_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid word without output word")
  `DOP_ASSERT_NEXT(a_push_to_skid, clk, rst_n, res_push && out_valid_r && out_stall, skid_valid_r, "result lost while output stalled")
  `DOP_ASSERT_NEXT(a_skid_drains, clk, rst_n, out_take && skid_valid_r, out_valid_r && !skid_valid_r, "skid word not moved to output")

endmodule

// File: src/dhcp_opt_parser.sv
// ----------------------------------------------------------------------------
// DHCP option byte parser
// Walks code-length-value options one byte per cycle while accept is high, and keeps the
// extracted fields; presents the finished result on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhcp_opt_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  dhcp_opt_pkg::in_word_t word,
  output dhcp_opt_pkg::out_word_t result
);

  dhcp_opt_pkg::parse_phase_t phase_r, phase_nxt;
  dhcp_opt_pkg::route_phase_t rt_phase_r, rt_phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  opt_len_r, opt_len_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] staged_r, staged_nxt;
  logic [7:0]  kept_type_r, kept_type_nxt;
  logic        kept_seen_r, kept_seen_nxt;
  logic [31:0] kept_mask_r, kept_mask_nxt;
  logic [31:0] kept_gw_r, kept_gw_nxt;
  logic [31:0] kept_dns_r, kept_dns_nxt;
  logic [31:0] kept_srv_r, kept_srv_nxt;
  logic        pfx_zero_r, pfx_zero_nxt;
  logic [5:0]  dest_left_r, dest_left_nxt;
  logic [31:0] router_r, router_nxt;
  logic [31:0] cand_r, cand_nxt;

  logic [7:0]  b;
  logic        commit;
  logic [8:0]  dest_sum;
  logic [31:0] lane;
  logic [31:0] router_ins;
  logic [2:0]  cnt_inc;

  assign b        = word.option_byte;
  assign dest_sum = {1'b0, b} + 9'd7;
  assign lane     = {24'd0, b} << {cnt_r[1:0], 3'b000};
  assign router_ins = router_r | lane;
  assign cnt_inc  = cnt_r + 3'd1;

  always_comb begin
    phase_nxt     = phase_r;
    rt_phase_nxt  = rt_phase_r;
    code_nxt      = code_r;
    left_nxt      = left_r;
    opt_len_nxt   = opt_len_r;
    cnt_nxt       = cnt_r;
    staged_nxt    = staged_r;
    kept_type_nxt = kept_type_r;
    kept_seen_nxt = kept_seen_r;
    kept_mask_nxt = kept_mask_r;
    kept_gw_nxt   = kept_gw_r;
    kept_dns_nxt  = kept_dns_r;
    kept_srv_nxt  = kept_srv_r;
    pfx_zero_nxt  = pfx_zero_r;
    dest_left_nxt = dest_left_r;
    router_nxt    = router_r;
    cand_nxt      = cand_r;
    commit        = 1'b0;

    if (accept) begin
      case (phase_r)
        dhcp_opt_pkg::PH_CODE: begin
          if (b == dhcp_opt_pkg::CODE_END) begin
            phase_nxt = dhcp_opt_pkg::PH_STOPPED;
          end else if (b != dhcp_opt_pkg::CODE_PAD) begin
            code_nxt  = b;
            phase_nxt = dhcp_opt_pkg::PH_LENGTH;
          end
        end
        dhcp_opt_pkg::PH_LENGTH: begin
          // A zero-length option never changes any kept value.
          opt_len_nxt   = b;
          left_nxt      = b;
          cnt_nxt       = 3'd0;
          staged_nxt    = 32'd0;
          rt_phase_nxt  = dhcp_opt_pkg::RT_PREFIX;
          pfx_zero_nxt  = 1'b1;
          dest_left_nxt = 6'd0;
          router_nxt    = 32'd0;
          cand_nxt      = kept_gw_r;
          phase_nxt     = (b == 8'd0) ? dhcp_opt_pkg::PH_CODE : dhcp_opt_pkg::PH_VALUE;
        end
        dhcp_opt_pkg::PH_VALUE: begin
          if (code_r == dhcp_opt_pkg::CODE_CLASSLESS) begin
            case (rt_phase_r)
              dhcp_opt_pkg::RT_PREFIX: begin
                pfx_zero_nxt  = (b == 8'd0);
                dest_left_nxt = dest_sum[8:3];
                router_nxt    = 32'd0;
                cnt_nxt       = 3'd0;
                rt_phase_nxt  = (dest_sum[8:3] == 6'd0) ? dhcp_opt_pkg::RT_ROUTER
                                                        : dhcp_opt_pkg::RT_DEST;
              end
              dhcp_opt_pkg::RT_DEST: begin
                dest_left_nxt = dest_left_r - 6'd1;
                if (dest_left_r == 6'd1) begin
                  rt_phase_nxt = dhcp_opt_pkg::RT_ROUTER;
                end
              end
              dhcp_opt_pkg::RT_ROUTER: begin
                if (cnt_inc >= dhcp_opt_pkg::ADDR_BYTES) begin
                  if (pfx_zero_r && (cand_r == 32'd0)) begin
                    cand_nxt = router_ins;
                  end
                  rt_phase_nxt = dhcp_opt_pkg::RT_PREFIX;
                  router_nxt   = 32'd0;
                  cnt_nxt      = 3'd0;
                end else begin
                  router_nxt = router_ins;
                  cnt_nxt    = cnt_inc;
                end
              end
              default: begin
                rt_phase_nxt = dhcp_opt_pkg::RT_PREFIX;
              end
            endcase
          end else if (cnt_r < dhcp_opt_pkg::ADDR_BYTES) begin
            staged_nxt = staged_r | lane;
            cnt_nxt    = cnt_inc;
          end
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            commit    = 1'b1;
            phase_nxt = dhcp_opt_pkg::PH_CODE;
          end
        end
        default: begin
        end
      endcase
    end

    if (commit) begin
      case (code_r)
        dhcp_opt_pkg::CODE_MSG_TYPE: begin
          if (opt_len_r == dhcp_opt_pkg::LEN_MSG_TYPE) begin
            kept_type_nxt = staged_nxt[7:0];
            kept_seen_nxt = 1'b1;
          end
        end
        dhcp_opt_pkg::CODE_NETMASK: begin
          if (opt_len_r == dhcp_opt_pkg::LEN_ADDR) begin
            kept_mask_nxt = staged_nxt;
          end
        end
        dhcp_opt_pkg::CODE_ROUTER: begin
          if (opt_len_r >= dhcp_opt_pkg::LEN_ADDR) begin
            kept_gw_nxt = staged_nxt;
          end
        end
        dhcp_opt_pkg::CODE_DNS: begin
          if (opt_len_r >= dhcp_opt_pkg::LEN_ADDR) begin
            kept_dns_nxt = staged_nxt;
          end
        end
        dhcp_opt_pkg::CODE_SERVER_ID: begin
          if (opt_len_r == dhcp_opt_pkg::LEN_ADDR) begin
            kept_srv_nxt = staged_nxt;
          end
        end
        dhcp_opt_pkg::CODE_CLASSLESS: begin
          kept_gw_nxt = cand_nxt;
        end
        default: begin
        end
      endcase
    end

    result.message_type       = kept_type_nxt;
    result.message_type_valid = kept_seen_nxt;
    result.subnet_mask        = kept_mask_nxt;
    result.router_address     = kept_gw_nxt;
    result.dns_address        = kept_dns_nxt;
    result.server_address     = kept_srv_nxt;

    // The last byte ends the area, so everything returns to its reset value.
    if (accept && word.last_byte) begin
      phase_nxt     = dhcp_opt_pkg::PH_CODE;
      rt_phase_nxt  = dhcp_opt_pkg::RT_PREFIX;
      code_nxt      = 8'd0;
      left_nxt      = 8'd0;
      opt_len_nxt   = 8'd0;
      cnt_nxt       = 3'd0;
      staged_nxt    = 32'd0;
      kept_type_nxt = 8'd0;
      kept_seen_nxt = 1'b0;
      kept_mask_nxt = 32'd0;
      kept_gw_nxt   = 32'd0;
      kept_dns_nxt  = 32'd0;
      kept_srv_nxt  = 32'd0;
      pfx_zero_nxt  = 1'b1;
      dest_left_nxt = 6'd0;
      router_nxt    = 32'd0;
      cand_nxt      = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dhcp_opt_pkg::PH_CODE;
      rt_phase_r  <= dhcp_opt_pkg::RT_PREFIX;
      code_r      <= 8'd0;
      left_r      <= 8'd0;
      opt_len_r   <= 8'd0;
      cnt_r       <= 3'd0;
      staged_r    <= 32'd0;
      kept_type_r <= 8'd0;
      kept_seen_r <= 1'b0;
      kept_mask_r <= 32'd0;
      kept_gw_r   <= 32'd0;
      kept_dns_r  <= 32'd0;
      kept_srv_r  <= 32'd0;
      pfx_zero_r  <= 1'b1;
      dest_left_r <= 6'd0;
      router_r    <= 32'd0;
      cand_r      <= 32'd0;
    end else begin
      phase_r     <= phase_nxt;
      rt_phase_r  <= rt_phase_nxt;
      code_r      <= code_nxt;
      left_r      <= left_nxt;
      opt_len_r   <= opt_len_nxt;
      cnt_r       <= cnt_nxt;
      staged_r    <= staged_nxt;
      kept_type_r <= kept_type_nxt;
      kept_seen_r <= kept_seen_nxt;
      kept_mask_r <= kept_mask_nxt;
      kept_gw_r   <= kept_gw_nxt;
      kept_dns_r  <= kept_dns_nxt;
      kept_srv_r  <= kept_srv_nxt;
      pfx_zero_r  <= pfx_zero_nxt;
      dest_left_r <= dest_left_nxt;
      router_r    <= router_nxt;
      cand_r      <= cand_nxt;
    end
  end

endmodule
